// ===== hdl/mosl_pkg.sv =====
package mosl_pkg;

    // Stream format constants
    localparam logic [7:0] ESC_BYTE   = 8'h98;
    localparam int         FILE_SLOTS = 256;
    localparam int         FILE_W     = $clog2(FILE_SLOTS);

    // Operation codes
    localparam logic [7:0] OPC_QUOTE = 8'h00;
    localparam logic [7:0] OPC_LOC   = 8'h01;
    localparam logic [7:0] OPC_SKIP  = 8'h02;
    localparam logic [7:0] OPC_ABSFX = 8'h03;
    localparam logic [7:0] OPC_RELFX = 8'h04;
    localparam logic [7:0] OPC_EXTFX = 8'h05;
    localparam logic [7:0] OPC_SRCF  = 8'h06;
    localparam logic [7:0] OPC_SRCL  = 8'h07;
    localparam logic [7:0] OPC_SPCL  = 8'h08;
    localparam logic [7:0] OPC_PRE   = 8'h09;
    localparam logic [7:0] OPC_END   = 8'h0a;

    // Result kinds (also used as the stop code; zero means running)
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] STOP_RUN   = 2'd0;

    typedef enum logic [11:0] {
        PH_PRE     = 12'b0000_0000_0001,
        PH_PRESKIP = 12'b0000_0000_0010,
        PH_MAIN    = 12'b0000_0000_0100,
        PH_QUOTE   = 12'b0000_0000_1000,
        PH_LOCH    = 12'b0000_0001_0000,
        PH_LOCL    = 12'b0000_0010_0000,
        PH_FIXOH   = 12'b0000_0100_0000,
        PH_FIXOL   = 12'b0000_1000_0000,
        PH_FIXRX   = 12'b0001_0000_0000,
        PH_FNAME   = 12'b0010_0000_0000,
        PH_SPEC    = 12'b0100_0000_0000,
        PH_SPECQ   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] address;
        logic [31:0] xor_value;
        logic        has_line;
        logic [7:0]  file_no;
        logic [15:0] line_no;
        logic        last;
    } result_t;

endpackage

// ===== hdl/mosl_out_buf.sv =====
module mosl_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push0,
    input  logic              push1,
    input  mosl_pkg::result_t res0,
    input  mosl_pkg::result_t res1,
    output logic              ready,
    output logic              m_valid,
    input  logic              m_ready,
    output mosl_pkg::result_t m_data
);
    import mosl_pkg::*;

    logic    v0_reg, v1_reg;
    result_t d0_reg, d1_reg;
    logic    pop;

    assign pop     = v0_reg && m_ready;
    // Take a new word only when the second slot is free and the first is empty or drains
    assign ready   = !v1_reg && (!v0_reg || m_ready);
    assign m_valid = v0_reg;
    assign m_data  = d0_reg;

    // Hold, advance or load the two result slots
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (v1_reg) begin
            if (pop) begin
                d0_reg <= d1_reg;
                v1_reg <= 1'b0;
            end
        end else if (push0) begin
            d0_reg <= res0;
            v0_reg <= 1'b1;
            if (push1) begin
                d1_reg <= res1;
                v1_reg <= 1'b1;
            end
        end else if (pop) begin
            v0_reg <= 1'b0;
        end
    end

endmodule

// ===== hdl/mmix_object_stream_loader.sv =====
// Object stream loader.
// s_word/s_valid/s_ready carry the object stream, one big-endian tetrabyte
// per word. m_* carries results: memory xor writes (address, xor_value, with
// optional file/line annotation), one format error, or one postamble result.
// m_last marks the final result caused by an input word; words that cause no
// result (preamble, loc, skip, file name text and the like) are simply absorbed.
// The first result of a word is registered and on m_* the cycle after the word is accepted.
// One word per cycle while the receiver keeps up, set by the single decode pass
// between the input handshake and the output register. The low word of an
// absolute fixup yields two results and holds s_ready low while the second waits.
// When the receiver stalls, the output register holds its result and s_ready
// follows m_ready while a result waits, staying low while both slots are full.
// Reset (aresetn low, synchronous) returns to expecting the preamble, clears
// location, file table and line state, and empties the result slots.
// After an error or the postamble every further word repeats that result.
module mmix_object_stream_loader (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_word,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [1:0]  m_kind,
    output logic [63:0] m_address,
    output logic [31:0] m_xor_value,
    output logic        m_has_line,
    output logic [7:0]  m_file_no,
    output logic [15:0] m_line_no,
    output logic        m_last,
    output logic        m_valid,
    input  logic        m_ready
);
    import mosl_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [7:0]            skip_reg, skip_next;
    logic [63:0]           loc_reg, loc_next;
    logic [7:0]            pend_reg, pend_next;
    logic [31:0]           fth_reg, fth_next;
    logic                  ext24_reg, ext24_next;
    logic [FILE_SLOTS-1:0] known_reg;
    logic [7:0]            file_reg, file_next;
    logic                  sel_reg, sel_next;
    logic [15:0]           line_reg, line_next;
    logic [1:0]            stop_reg, stop_next;

    logic        accept, buf_ready, known_set;
    logic [1:0]  n_res;
    result_t     r0, r1, m_data;
    logic        do_main, do_load, err, done;
    logic        esc;
    logic [7:0]  op, y, z;
    logic [15:0] yz;
    logic [7:0]  skip_dec;
    logic signed [25:0] rx_delta;
    logic [63:0] rx_tgt, fixr_tgt;
    logic [61:0] fixo_hi_word;

    assign esc = (s_word[31:24] == ESC_BYTE);
    assign op  = s_word[23:16];
    assign y   = s_word[15:8];
    assign z   = s_word[7:0];
    assign yz  = s_word[15:0];

    assign skip_dec = skip_reg - 8'd1;

    // Target arithmetic for the relative and absolute fixups
    assign rx_delta = (s_word[24] ? (ext24_reg ? 26'sh1000000 : 26'sh0010000) : 26'sd0)
                      - $signed({2'b00, s_word[23:0]});
    assign rx_tgt   = loc_reg + {{36{rx_delta[25]}}, rx_delta, 2'b00};
    assign fixr_tgt = loc_reg - {46'd0, yz, 2'b00};
    assign fixo_hi_word = {fth_reg, s_word[31:2]} + 62'd1;

    assign accept = s_valid && s_ready;
    assign s_ready = buf_ready;

    // Decode one word against the current stream state
    always_comb begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        loc_next   = loc_reg;
        pend_next  = pend_reg;
        fth_next   = fth_reg;
        ext24_next = ext24_reg;
        file_next  = file_reg;
        sel_next   = sel_reg;
        line_next  = line_reg;
        stop_next  = stop_reg;
        known_set  = 1'b0;
        n_res      = 2'd0;
        r0         = '0;
        r1         = '0;
        do_main    = 1'b0;
        do_load    = 1'b0;
        err        = 1'b0;
        done       = 1'b0;

        if (stop_reg != STOP_RUN) begin
            n_res   = 2'd1;
            r0.kind = stop_reg;
        end else begin
            unique case (phase_reg)
                PH_PRE: begin
                    if (s_word[31:16] != {ESC_BYTE, OPC_PRE} || y != 8'd1) begin
                        err = 1'b1;
                    end else if (z == 8'd0) begin
                        phase_next = PH_MAIN;
                    end else begin
                        skip_next  = z;
                        phase_next = PH_PRESKIP;
                    end
                end
                PH_PRESKIP, PH_FNAME: begin
                    skip_next = skip_dec;
                    if (skip_dec == 8'd0) begin
                        phase_next = PH_MAIN;
                    end
                end
                PH_QUOTE: begin
                    phase_next = PH_MAIN;
                    do_load    = 1'b1;
                end
                PH_LOCH: begin
                    loc_next[63:32] = {pend_reg, 24'd0} + s_word;
                    phase_next      = PH_LOCL;
                end
                PH_LOCL: begin
                    loc_next[31:0] = s_word;
                    phase_next     = PH_MAIN;
                end
                PH_FIXOH: begin
                    fth_next   = {pend_reg, 24'd0} + s_word;
                    phase_next = PH_FIXOL;
                end
                PH_FIXOL: begin
                    n_res        = 2'd2;
                    r0.address   = {fth_reg, s_word[31:2], 2'b00};
                    r0.xor_value = loc_reg[63:32];
                    r1.address   = {fixo_hi_word, 2'b00};
                    r1.xor_value = loc_reg[31:0];
                    phase_next   = PH_MAIN;
                end
                PH_FIXRX: begin
                    phase_next = PH_MAIN;
                    if (s_word[31:25] != 7'd0) begin
                        err = 1'b1;
                    end else begin
                        n_res        = 2'd1;
                        r0.address   = {rx_tgt[63:2], 2'b00};
                        r0.xor_value = s_word;
                    end
                end
                PH_SPEC: begin
                    if (esc) begin
                        if (op == OPC_QUOTE && yz == 16'd1) begin
                            phase_next = PH_SPECQ;
                        end else begin
                            phase_next = PH_MAIN;
                            do_main    = 1'b1;
                        end
                    end
                end
                PH_SPECQ: begin
                    phase_next = PH_SPEC;
                end
                PH_MAIN: begin
                    do_main = 1'b1;
                end
                default: begin
                    phase_next = PH_MAIN;
                    do_main    = 1'b1;
                end
            endcase

            // Body word: plain data or a lopcode
            if (do_main) begin
                if (!esc) begin
                    do_load = 1'b1;
                end else begin
                    unique case (op)
                        OPC_QUOTE: begin
                            if (yz != 16'd1) begin
                                err = 1'b1;
                            end else begin
                                phase_next = PH_QUOTE;
                            end
                        end
                        OPC_LOC, OPC_ABSFX: begin
                            if (z == 8'd2) begin
                                pend_next  = y;
                                phase_next = (op == OPC_LOC) ? PH_LOCH : PH_FIXOH;
                            end else if (z == 8'd1) begin
                                if (op == OPC_LOC) begin
                                    loc_next[63:32] = {y, 24'd0};
                                    phase_next      = PH_LOCL;
                                end else begin
                                    fth_next   = {y, 24'd0};
                                    phase_next = PH_FIXOL;
                                end
                            end else begin
                                err = 1'b1;
                            end
                        end
                        OPC_SKIP: begin
                            loc_next = loc_reg + {48'd0, yz};
                        end
                        OPC_RELFX: begin
                            n_res        = 2'd1;
                            r0.address   = {fixr_tgt[63:2], 2'b00};
                            r0.xor_value = {16'd0, yz};
                        end
                        OPC_EXTFX: begin
                            if (yz != 16'd16 && yz != 16'd24) begin
                                err = 1'b1;
                            end else begin
                                ext24_next = (yz == 16'd24);
                                phase_next = PH_FIXRX;
                            end
                        end
                        OPC_SRCF: begin
                            // Every 8-bit file number has a slot, so no range check
                            if (known_reg[y[FILE_W-1:0]]) begin
                                if (z != 8'd0) begin
                                    err = 1'b1;
                                end
                            end else if (z == 8'd0) begin
                                err = 1'b1;
                            end else begin
                                known_set  = 1'b1;
                                skip_next  = z;
                                phase_next = PH_FNAME;
                            end
                            if (!err) begin
                                file_next = y;
                                sel_next  = 1'b1;
                                line_next = 16'd0;
                            end
                        end
                        OPC_SRCL: begin
                            if (!sel_reg) begin
                                err = 1'b1;
                            end else begin
                                line_next = yz;
                            end
                        end
                        OPC_SPCL: begin
                            phase_next = PH_SPEC;
                        end
                        OPC_END: begin
                            if (y != 8'd0 || z < 8'd32) begin
                                err = 1'b1;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        default: begin
                            err = 1'b1;
                        end
                    endcase
                end
            end

            // Load a data word at the current tetra, tagging it with file and line while the line is nonzero
            if (do_load) begin
                n_res        = 2'd1;
                r0.address   = {loc_reg[63:2], 2'b00};
                r0.xor_value = s_word;
                if (line_reg != 16'd0) begin
                    r0.has_line = 1'b1;
                    r0.file_no  = file_reg;
                    r0.line_no  = line_reg;
                    line_next   = line_reg + 16'd1;
                end
                loc_next = {loc_reg[63:2] + 62'd1, 2'b00};
            end

            // Stop on a malformed stream or the postamble
            if (err || done) begin
                stop_next = err ? KIND_ERROR : KIND_DONE;
                n_res     = 2'd1;
                r0        = '0;
                r0.kind   = stop_next;
            end
        end

        if (n_res == 2'd2) begin
            r1.last = 1'b1;
        end else if (n_res == 2'd1) begin
            r0.last = 1'b1;
        end
    end

    // Advance the stream state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PRE;
            skip_reg  <= 8'd0;
            loc_reg   <= 64'd0;
            pend_reg  <= 8'd0;
            fth_reg   <= 32'd0;
            ext24_reg <= 1'b0;
            known_reg <= '0;
            file_reg  <= 8'd0;
            sel_reg   <= 1'b0;
            line_reg  <= 16'd0;
            stop_reg  <= STOP_RUN;
        end else if (accept) begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            loc_reg   <= loc_next;
            pend_reg  <= pend_next;
            fth_reg   <= fth_next;
            ext24_reg <= ext24_next;
            file_reg  <= file_next;
            sel_reg   <= sel_next;
            line_reg  <= line_next;
            stop_reg  <= stop_next;
            if (known_set) begin
                known_reg[y[FILE_W-1:0]] <= 1'b1;
            end
        end
    end

    mosl_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push0   (accept && (n_res != 2'd0)),
        .push1   (accept && (n_res == 2'd2)),
        .res0    (r0),
        .res1    (r1),
        .ready   (buf_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign m_kind      = m_data.kind;
    assign m_address   = m_data.address;
    assign m_xor_value = m_data.xor_value;
    assign m_has_line  = m_data.has_line;
    assign m_file_no   = m_data.file_no;
    assign m_line_no   = m_data.line_no;
    assign m_last      = m_data.last;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mosl_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [31:0] s_word;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  m_kind;
    logic [63:0] m_address;
    logic [31:0] m_xor_value;
    logic        m_has_line;
    logic [7:0]  m_file_no;
    logic [15:0] m_line_no;
    logic        m_last;
    logic        m_valid;
    logic        m_ready;

    mmix_object_stream_loader DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_word      (s_word),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_kind      (m_kind),
        .m_address   (m_address),
        .m_xor_value (m_xor_value),
        .m_has_line  (m_has_line),
        .m_file_no   (m_file_no),
        .m_line_no   (m_line_no),
        .m_last      (m_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Loader state as the testbench tracks it
    phase_t      ld_phase;
    logic [7:0]  skip_left;
    logic [63:0] cur_loc;
    logic [7:0]  hi_byte;
    logic [31:0] fixo_high;
    logic        wide24;
    bit          file_known [0:FILE_SLOTS-1];
    logic [7:0]  cur_file;
    logic        file_sel;
    logic [15:0] cur_line;
    logic [1:0]  halt_kind;

    result_t word_results [$];
    result_t results_due [$];

    int mismatches    = 0;
    int words_sent    = 0;
    int src_max_gap   = 10;
    int sink_max_gap  = 10;
    int sink_hold_req = 0;

    function automatic void reset_loader_state();
        ld_phase  = PH_PRE;
        skip_left = 8'h00;
        cur_loc   = 64'h0;
        hi_byte   = 8'h00;
        fixo_high = 32'h0;
        wide24    = 1'b0;
        foreach (file_known[i]) file_known[i] = 1'b0;
        cur_file  = 8'h00;
        file_sel  = 1'b0;
        cur_line  = 16'h0;
        halt_kind = STOP_RUN;
    endfunction

    function automatic void emit(logic [1:0] kind, logic [63:0] addr, logic [31:0] val,
                                 logic has, logic [7:0] fno, logic [15:0] lno);
        result_t r;
        r.kind      = kind;
        r.address   = {addr[63:2], 2'b00};
        r.xor_value = val;
        r.has_line  = has;
        r.file_no   = fno;
        r.line_no   = lno;
        r.last      = 1'b0;
        word_results.push_back(r);
    endfunction

    function automatic void stop_stream(logic [1:0] kind);
        halt_kind = kind;
        emit(kind, 64'h0, 32'h0, 1'b0, 8'h00, 16'h0);
    endfunction

    // Load one tetrabyte at the current location, tagged while a line is live
    function automatic void load_tetra(logic [31:0] w);
        if (cur_line != 16'h0) begin
            emit(KIND_WRITE, cur_loc, w, 1'b1, cur_file, cur_line);
            cur_line = cur_line + 16'd1;
        end else begin
            emit(KIND_WRITE, cur_loc, w, 1'b0, 8'h00, 16'h0);
        end
        cur_loc = {cur_loc[63:2] + 62'd1, 2'b00};
    endfunction

    // Handle a word in the body of the stream: plain load or lopcode
    function automatic void decode_body_word(logic [31:0] w);
        logic [7:0]  op;
        logic [7:0]  y;
        logic [7:0]  z;
        logic [15:0] yz;
        logic [63:0] tgt;
        op = w[23:16];
        y  = w[15:8];
        z  = w[7:0];
        yz = w[15:0];
        if (w[31:24] != ESC_BYTE) begin
            load_tetra(w);
        end else begin
            case (op)
                OPC_QUOTE: begin
                    if (yz != 16'd1) stop_stream(KIND_ERROR);
                    else ld_phase = PH_QUOTE;
                end
                OPC_LOC, OPC_ABSFX: begin
                    if (z == 8'd2) begin
                        hi_byte  = y;
                        ld_phase = (op == OPC_LOC) ? PH_LOCH : PH_FIXOH;
                    end else if (z == 8'd1) begin
                        if (op == OPC_LOC) cur_loc = {y, 24'h0, cur_loc[31:0]};
                        else fixo_high = {y, 24'h0};
                        ld_phase = (op == OPC_LOC) ? PH_LOCL : PH_FIXOL;
                    end else begin
                        stop_stream(KIND_ERROR);
                    end
                end
                OPC_SKIP: cur_loc = cur_loc + {48'h0, yz};
                OPC_RELFX: begin
                    tgt = cur_loc - {46'h0, yz, 2'b00};
                    emit(KIND_WRITE, tgt, {16'h0, yz}, 1'b0, 8'h00, 16'h0);
                end
                OPC_EXTFX: begin
                    if (yz != 16'd16 && yz != 16'd24) begin
                        stop_stream(KIND_ERROR);
                    end else begin
                        wide24   = (yz == 16'd24);
                        ld_phase = PH_FIXRX;
                    end
                end
                OPC_SRCF: begin
                    if (file_known[y] ? (z != 8'd0) : (z == 8'd0)) begin
                        stop_stream(KIND_ERROR);
                    end else begin
                        if (!file_known[y]) begin
                            file_known[y] = 1'b1;
                            skip_left     = z;
                            ld_phase      = PH_FNAME;
                        end
                        cur_file = y;
                        file_sel = 1'b1;
                        cur_line = 16'h0;
                    end
                end
                OPC_SRCL: begin
                    if (!file_sel) stop_stream(KIND_ERROR);
                    else cur_line = yz;
                end
                OPC_SPCL: ld_phase = PH_SPEC;
                OPC_END: begin
                    if (y != 8'd0 || z < 8'd32) stop_stream(KIND_ERROR);
                    else stop_stream(KIND_DONE);
                end
                default: stop_stream(KIND_ERROR);
            endcase
        end
    endfunction

    // Work out the results of one accepted word and queue them
    function automatic void predict_word(logic [31:0] w);
        logic [63:0] tgt;
        logic [63:0] span;
        result_t     r;
        word_results.delete();
        if (halt_kind != STOP_RUN) begin
            emit(halt_kind, 64'h0, 32'h0, 1'b0, 8'h00, 16'h0);
        end else begin
            case (ld_phase)
                PH_PRE: begin
                    if (w[31:16] != {ESC_BYTE, OPC_PRE} || w[15:8] != 8'd1) begin
                        stop_stream(KIND_ERROR);
                    end else if (w[7:0] == 8'd0) begin
                        ld_phase = PH_MAIN;
                    end else begin
                        skip_left = w[7:0];
                        ld_phase  = PH_PRESKIP;
                    end
                end
                PH_PRESKIP, PH_FNAME: begin
                    skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0) ld_phase = PH_MAIN;
                end
                PH_QUOTE: begin
                    ld_phase = PH_MAIN;
                    load_tetra(w);
                end
                PH_LOCH: begin
                    cur_loc[63:32] = {hi_byte, 24'h0} + w;
                    ld_phase = PH_LOCL;
                end
                PH_LOCL: begin
                    cur_loc[31:0] = w;
                    ld_phase = PH_MAIN;
                end
                PH_FIXOH: begin
                    fixo_high = {hi_byte, 24'h0} + w;
                    ld_phase  = PH_FIXOL;
                end
                PH_FIXOL: begin
                    tgt = {fixo_high, w};
                    emit(KIND_WRITE, tgt, cur_loc[63:32], 1'b0, 8'h00, 16'h0);
                    emit(KIND_WRITE, tgt + 64'd4, cur_loc[31:0], 1'b0, 8'h00, 16'h0);
                    ld_phase = PH_MAIN;
                end
                PH_FIXRX: begin
                    ld_phase = PH_MAIN;
                    if (w[31:25] != 7'd0) begin
                        stop_stream(KIND_ERROR);
                    end else begin
                        // bit 24 set means a forward offset from the top of the width
                        if (w[24]) begin
                            span = wide24 ? (64'h1 << 26) : (64'h1 << 18);
                            tgt  = cur_loc + span - {38'h0, w[23:0], 2'b00};
                        end else begin
                            tgt = cur_loc - {38'h0, w[23:0], 2'b00};
                        end
                        emit(KIND_WRITE, tgt, w, 1'b0, 8'h00, 16'h0);
                    end
                end
                PH_SPEC: begin
                    if (w[31:24] == ESC_BYTE) begin
                        if (w[23:16] == OPC_QUOTE && w[15:0] == 16'd1) begin
                            ld_phase = PH_SPECQ;
                        end else begin
                            ld_phase = PH_MAIN;
                            decode_body_word(w);
                        end
                    end
                end
                PH_SPECQ: ld_phase = PH_SPEC;
                default: begin
                    ld_phase = PH_MAIN;
                    decode_body_word(w);
                end
            endcase
        end
        if (word_results.size() > 0) begin
            r = word_results.pop_back();
            r.last = 1'b1;
            word_results.push_back(r);
            foreach (word_results[i]) results_due.push_back(word_results[i]);
        end
    endfunction

    function automatic logic [31:0] lop_word(logic [7:0] op, logic [7:0] y, logic [7:0] z);
        return {ESC_BYTE, op, y, z};
    endfunction

    function automatic logic [31:0] plain_word();
        logic [31:0] w;
        do w = $urandom; while (w[31:24] == ESC_BYTE);
        return w;
    endfunction

    // Offer one word after a random gap, hold it until taken, then predict.
    // Entered and left at a falling edge.
    task automatic push_word(input logic [31:0] w);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_word  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_word(w);
        words_sent++;
        @(negedge aclk);
    endtask

    // Result receiver: random gap before each result, long holds on request
    initial begin : result_sink
        int gap;
        int hold;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (sink_hold_req > 0) begin
                hold = sink_hold_req;
                sink_hold_req = 0;
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            gap = $urandom_range(0, sink_max_gap);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each taken result with the oldest one due
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result expected none actual kind %0d addr %h val %h",
                         $time, m_kind, m_address, m_xor_value);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_kind));
                check_field("address", want.address, m_address);
                check_field("xor_value", 64'(want.xor_value), 64'(m_xor_value));
                check_field("has_line", 64'(want.has_line), 64'(m_has_line));
                check_field("file_no", 64'(want.file_no), 64'(m_file_no));
                check_field("line_no", 64'(want.line_no), 64'(m_line_no));
                check_field("last", 64'(want.last), 64'(m_last));
            end
        end
    end

    task automatic test_preamble();
        push_word(lop_word(OPC_PRE, 8'd1, 8'd2));
        push_word(lop_word(OPC_QUOTE, 8'd0, 8'd1));
        push_word($urandom);
    endtask

    task automatic test_loads_and_skip();
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        // quoted word that looks like a lopcode
        push_word(lop_word(OPC_QUOTE, 8'd0, 8'd1));
        push_word(lop_word(OPC_QUOTE, 8'd0, 8'd1));
        // skip leaves the location unaligned
        push_word(lop_word(OPC_SKIP, 8'hff, 8'hff));
        push_word(plain_word());
        // high part of a two-word loc wraps at 32 bits
        push_word(lop_word(OPC_LOC, 8'hff, 8'd2));
        push_word(32'hffff_ffff);
        push_word(32'hffff_fffd);
        push_word(plain_word());
    endtask

    task automatic test_fixups();
        push_word(lop_word(OPC_RELFX, 8'hff, 8'hff));
        push_word(lop_word(OPC_ABSFX, 8'h12, 8'd1));
        push_word(32'h0000_0003);
        push_word(lop_word(OPC_ABSFX, 8'hff, 8'd2));
        push_word(32'h0100_0000);
        push_word(32'hffff_fffc);
        push_word(lop_word(OPC_EXTFX, 8'd0, 8'd16));
        push_word(32'h0100_0001);
        push_word(lop_word(OPC_EXTFX, 8'd0, 8'd24));
        push_word(32'h00ff_ffff);
    endtask

    task automatic test_files_and_lines();
        push_word(lop_word(OPC_SRCF, 8'hff, 8'd2));
        push_word($urandom);
        push_word($urandom);
        // line counter wraps: the second load goes untagged
        push_word(lop_word(OPC_SRCL, 8'hff, 8'hff));
        push_word(plain_word());
        push_word(plain_word());
        push_word(lop_word(OPC_SRCF, 8'hff, 8'd0));
        push_word(lop_word(OPC_SRCL, 8'd0, 8'd1));
        push_word(plain_word());
    endtask

    task automatic test_spec();
        push_word(lop_word(OPC_SPCL, 8'h12, 8'h34));
        push_word(plain_word());
        push_word(lop_word(OPC_QUOTE, 8'd0, 8'd1));
        push_word(lop_word(OPC_SRCL, 8'd0, 8'd0));
        // a non-quote lopcode ends the special data
        push_word(lop_word(OPC_LOC, 8'd0, 8'd1));
        push_word(32'h0000_1000);
        push_word(plain_word());
    endtask

    // Select a file: known ones again with Z = 0, new ones with a name of one to three words, now and then up to 255
    task automatic send_file_select();
        logic [7:0] y;
        int         n;
        y = 8'($urandom);
        if (file_known[y]) begin
            push_word(lop_word(OPC_SRCF, y, 8'd0));
        end else begin
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(4, 255) : $urandom_range(1, 3);
            push_word(lop_word(OPC_SRCF, y, 8'(n)));
            repeat (n) push_word($urandom);
        end
    endtask

    // One well-formed piece of stream with random content
    task automatic send_random_segment();
        int         pick;
        int         n;
        logic [7:0] y;
        logic [7:0] z;
        pick = $urandom_range(0, 99);
        y    = 8'($urandom);
        z    = 8'($urandom);
        if (pick < 40) begin
            n = $urandom_range(1, 4);
            repeat (n) push_word(plain_word());
        end else if (pick < 46) begin
            push_word(lop_word(OPC_QUOTE, 8'd0, 8'd1));
            push_word($urandom);
        end else if (pick < 66) begin
            // loc or fixo, one- or two-word high part
            push_word(lop_word(pick < 56 ? OPC_LOC : OPC_ABSFX, y, z[0] ? 8'd1 : 8'd2));
            if (!z[0]) push_word($urandom);
            push_word($urandom);
        end else if (pick < 70) begin
            push_word(lop_word(OPC_SKIP, y, z));
        end else if (pick < 75) begin
            push_word(lop_word(OPC_RELFX, y, z));
        end else if (pick < 80) begin
            push_word(lop_word(OPC_EXTFX, 8'd0, z[0] ? 8'd24 : 8'd16));
            push_word($urandom & 32'h01ff_ffff);
        end else if (pick < 86 || (pick < 93 && !file_sel)) begin
            send_file_select();
        end else if (pick < 93) begin
            if (z[1:0] == 2'b00) push_word(lop_word(OPC_SRCL, 8'hff, 8'hfe));
            else push_word(lop_word(OPC_SRCL, y, z));
        end else begin
            push_word(lop_word(OPC_SPCL, y, z));
            n = $urandom_range(0, 3);
            repeat (n) begin
                if ($urandom_range(0, 1) == 1) begin
                    push_word(lop_word(OPC_QUOTE, 8'd0, 8'd1));
                    push_word($urandom);
                end else begin
                    push_word(plain_word());
                end
            end
            push_word(lop_word(OPC_SKIP, y, z));
        end
    endtask

    task automatic test_random_stream(input int count);
        int stop_at;
        int mode;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            // switch idling now and then, including stretches with none
            if ($urandom_range(0, 14) == 0) begin
                mode = $urandom_range(0, 3);
                src_max_gap  = mode[0] ? 10 : 0;
                sink_max_gap = mode[1] ? 10 : 0;
            end
            send_random_segment();
        end
        src_max_gap  = 10;
        sink_max_gap = 10;
    endtask

    task automatic test_backpressure();
        src_max_gap   = 0;
        sink_hold_req = 200;
        repeat (40) push_word(plain_word());
        src_max_gap   = 10;
    endtask

    // End the stream with the postamble or one malformed word, then keep feeding
    task automatic test_stop();
        int         pick;
        int         i;
        logic [7:0] y;
        pick = $urandom_range(0, 19);
        y    = 8'($urandom);
        case (pick)
            10: push_word(lop_word(OPC_END, 8'($urandom_range(1, 255)), 8'd32));
            11: push_word(lop_word(OPC_END, 8'd0, 8'($urandom_range(0, 31))));
            12: push_word(lop_word(OPC_QUOTE, y, (y == 8'd0) ? 8'd2 : 8'd1));
            13: push_word(lop_word(OPC_LOC, y, 8'($urandom_range(3, 255))));
            14: push_word(lop_word(OPC_EXTFX, 8'd0, 8'd32));
            15: begin
                push_word(lop_word(OPC_EXTFX, 8'd0, 8'd16));
                push_word($urandom | 32'h0200_0000);
            end
            16: push_word(lop_word(OPC_SRCF, 8'hff, 8'($urandom_range(1, 255))));
            17: begin
                // a new file with an empty name
                for (i = 0; i < FILE_SLOTS && file_known[i]; i++) ;
                if (i < FILE_SLOTS) push_word(lop_word(OPC_SRCF, 8'(i), 8'd0));
                else push_word(lop_word(OPC_PRE, 8'd1, 8'd0));
            end
            18: push_word(lop_word(OPC_PRE, 8'd1, 8'd0));
            19: push_word(lop_word(8'($urandom_range(11, 255)), y, 8'($urandom)));
            default: push_word(lop_word(OPC_END, 8'd0, 8'($urandom_range(32, 255))));
        endcase
        repeat (30) begin
            if ($urandom_range(0, 1) == 1) push_word($urandom);
            else push_word(lop_word(8'($urandom), 8'($urandom), 8'($urandom)));
        end
    endtask

    initial begin : stimulus
        int n;
        s_word  = 32'h0;
        s_valid = 1'b0;
        aresetn = 1'b0;
        reset_loader_state();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_preamble();
        test_loads_and_skip();
        test_fixups();
        test_files_and_lines();
        test_spec();
        test_random_stream(370);
        test_backpressure();
        test_random_stream(370);
        test_stop();
        s_valid <= 1'b0;

        // drain what is still due, with a bound
        for (n = 0; n < 5000 && results_due.size() != 0; n++) @(posedge aclk);
        if (results_due.size() != 0) begin
            $display("%0t: results missing expected %0d more actual 0",
                     $time, results_due.size());
            mismatches++;
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mosl_pkg.sv
hdl/mosl_out_buf.sv
hdl/mmix_object_stream_loader.sv
tb/testbench.sv
